[src/ppd_pkg.sv]
// Package for the packed pattern event decoder: result word type, register
// indexes, widths and clamp limits. Depends on nothing; all other sources use it.
`timescale 1ns / 1ps

package ppd_pkg;

  // Field widths of the byte and result channels.
  localparam int unsigned ByteW    = 8;
  localparam int unsigned RowW     = 10;
  localparam int unsigned ChanW    = 5;
  localparam int unsigned MaskW    = 6;
  localparam int unsigned ChanCntW = 8;
  localparam int unsigned FlagW    = 7;
  localparam int unsigned FieldsW  = MaskW * ByteW;

  // Configuration port.
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 10;
  localparam int unsigned ChanRegW  = 6;
  localparam int unsigned RowRegW   = 10;

  localparam logic [CfgIdxW-1:0] RegChannelCount = 1'b0;
  localparam logic [CfgIdxW-1:0] RegRowCount     = 1'b1;

  localparam logic [ChanRegW-1:0] ChannelCountReset = 6'd32;
  localparam logic [RowRegW-1:0]  RowCountReset     = 10'd64;

  // Upper limits that the register values are clamped to.
  localparam logic [ChanCntW-1:0] MaxChannelCount = 8'd32;
  localparam logic [RowW-1:0]     MaxRowCount     = 10'd999;

  // Saturation point of the channel counter.
  localparam logic [ChanCntW-1:0] ChannelSat = 8'hff;

  // A fresh event starts with the note empty and every other field zero.
  localparam logic [FieldsW-1:0] FieldsInit = {{(FieldsW - ByteW){1'b0}}, 8'hff};

  // Depth of the queue between the decoder and the output stage.
  localparam int unsigned QueueDepth = 2;

  // One result word.
  typedef struct packed {
    logic               event_valid;
    logic [RowW-1:0]    row_index;
    logic [ChanW-1:0]   channel_index;
    logic [MaskW-1:0]   present_mask;
    logic [FieldsW-1:0] fields;        // byte k holds field k, note in byte 0
    logic               pattern_end;
  } result_t;

  // Queue status seen by the output stage.
  typedef struct packed {
    logic    empty;
    result_t head;
  } q_status_t;

endpackage

[src/ppd_if.sv]
// Channel interfaces of the packed pattern event decoder: the byte input
// channel and the result channel. Depends on ppd_pkg for field widths.
`timescale 1ns / 1ps

interface ppd_byte_if;
  logic                      valid;
  logic                      ready;
  logic [ppd_pkg::ByteW-1:0] data_byte;
  logic                      last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ppd_event_if;
  logic                       valid;
  logic                       ready;
  logic                       event_valid;
  logic [ppd_pkg::RowW-1:0]   row_index;
  logic [ppd_pkg::ChanW-1:0]  channel_index;
  logic [ppd_pkg::MaskW-1:0]  present_mask;
  logic [ppd_pkg::ByteW-1:0]  note_value;
  logic [ppd_pkg::ByteW-1:0]  instrument_value;
  logic [ppd_pkg::ByteW-1:0]  first_command;
  logic [ppd_pkg::ByteW-1:0]  first_param;
  logic [ppd_pkg::ByteW-1:0]  second_command;
  logic [ppd_pkg::ByteW-1:0]  second_param;
  logic                       pattern_end;

  modport source (
    output valid, output event_valid, output row_index, output channel_index,
    output present_mask, output note_value, output instrument_value,
    output first_command, output first_param, output second_command,
    output second_param, output pattern_end, input ready
  );
  modport sink (
    input valid, input event_valid, input row_index, input channel_index,
    input present_mask, input note_value, input instrument_value,
    input first_command, input first_param, input second_command,
    input second_param, input pattern_end, output ready
  );
endinterface

[src/ppd_front.sv]
// Front end of the decoder: holds the configuration and parse state, decodes
// one pattern byte per accepted cycle, pushes result words; depends on ppd_pkg.
`timescale 1ns / 1ps

module ppd_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ppd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ppd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         accept_i,
  input  logic [ppd_pkg::ByteW-1:0]    data_byte_i,
  input  logic                         last_byte_i,
  output logic                         push_o,
  output ppd_pkg::result_t             result_o
);
  import ppd_pkg::*;

  logic [ChanRegW-1:0] chan_cnt_q;
  logic [RowRegW-1:0]  row_cnt_q;
  logic [RowW-1:0]     row_q, row_d;
  logic [ChanCntW-1:0] chan_q, chan_d;
  logic [FlagW-1:0]    pend_q, pend_d;
  logic                in_event_q, in_event_d;
  logic [FieldsW-1:0]  fields_q, fields_d;
  logic [MaskW-1:0]    mask_q, mask_d;

  logic [ChanCntW-1:0] eff_chan;
  logic [RowW-1:0]     eff_rows;
  logic [FlagW-1:0]    low_flag;
  logic                done;
  logic                got;
  result_t             res;

  // Clamp the registers to the supported limits.
  assign eff_chan = ({2'b00, chan_cnt_q} < MaxChannelCount) ? {2'b00, chan_cnt_q}
                                                            : MaxChannelCount;
  assign eff_rows = (row_cnt_q < MaxRowCount) ? row_cnt_q : MaxRowCount;

  // Lowest flag bit still to be served selects what the byte is.
  assign low_flag = pend_q & (~pend_q + 7'd1);

  // Next parse state and the result word for this byte.
  always_comb begin
    row_d      = row_q;
    chan_d     = chan_q;
    pend_d     = pend_q;
    in_event_d = in_event_q;
    fields_d   = fields_q;
    mask_d     = mask_q;
    done       = 1'b0;
    got        = 1'b0;
    res        = '0;

    if (row_q < eff_rows) begin
      if (!in_event_q) begin
        if (data_byte_i == '0) begin
          // End of row.
          chan_d = '0;
          row_d  = row_q + 10'd1;
        end else begin
          // Flag byte opens an event.
          in_event_d = 1'b1;
          pend_d     = data_byte_i[FlagW-1:0];
          fields_d   = FieldsInit;
          mask_d     = '0;
          done       = (data_byte_i[FlagW-1:0] == '0);
        end
      end else begin
        // Data byte for the announced field.
        if (low_flag[0]) begin
          chan_d = data_byte_i;
        end
        for (int k = 0; k < MaskW; k++) begin
          if (low_flag[k+1]) begin
            fields_d[k*ByteW +: ByteW] = data_byte_i;
            mask_d[k]                  = 1'b1;
          end
        end
        pend_d = pend_q & ~low_flag;
        done   = (pend_d == '0);
      end

      // A complete event goes out if its channel is in range.
      if (done) begin
        if (chan_d < eff_chan) begin
          res.event_valid   = 1'b1;
          res.row_index     = row_d;
          res.channel_index = chan_d[ChanW-1:0];
          res.present_mask  = mask_d;
          res.fields        = fields_d;
          got               = 1'b1;
        end
        if (chan_d != ChannelSat) begin
          chan_d = chan_d + 8'd1;
        end
        in_event_d = 1'b0;
      end
    end

    // The last byte flushes a partial event and clears the state.
    if (last_byte_i) begin
      if (in_event_d && (chan_d < eff_chan)) begin
        res.event_valid   = 1'b1;
        res.row_index     = row_d;
        res.channel_index = chan_d[ChanW-1:0];
        res.present_mask  = mask_d;
        res.fields        = fields_d;
      end
      res.pattern_end = 1'b1;
      got             = 1'b1;
      row_d           = '0;
      chan_d          = '0;
      pend_d          = '0;
      in_event_d      = 1'b0;
      fields_d        = '0;
      mask_d          = '0;
    end
  end

  assign push_o   = accept_i && got;
  assign result_o = res;

  // Configuration registers and parse state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cnt_q <= ChannelCountReset;
      row_cnt_q  <= RowCountReset;
      row_q      <= '0;
      chan_q     <= '0;
      pend_q     <= '0;
      in_event_q <= 1'b0;
      fields_q   <= '0;
      mask_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegChannelCount: chan_cnt_q <= cfg_data_i[ChanRegW-1:0];
          RegRowCount:     row_cnt_q  <= cfg_data_i[RowRegW-1:0];
          default: ;
        endcase
      end
      if (accept_i) begin
        row_q      <= row_d;
        chan_q     <= chan_d;
        pend_q     <= pend_d;
        in_event_q <= in_event_d;
        fields_q   <= fields_d;
        mask_q     <= mask_d;
      end
    end
  end

endmodule

[src/ppd_queue.sv]
// Short result queue between the decoder front end and the output stage.
// Depends on ppd_pkg for the result word and the queue depth.
`timescale 1ns / 1ps

module ppd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ppd_pkg::result_t   data_i,
  input  logic               pop_i,
  output logic               full_o,
  output ppd_pkg::q_status_t status_o
);
  import ppd_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(QueueDepth);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);

  result_t         mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_pop;

  assign full_o         = (count_q == DepthC);
  assign do_pop         = pop_i && (count_q != '0);
  assign status_o.empty = (count_q == '0);
  assign status_o.head  = mem_q[rd_ptr_q];

  // Storage; entries need no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

[src/ppd_back.sv]
// Output stage: takes words from the queue into a register and drives the
// result channel. Depends on ppd_pkg and the ppd_event_if interface.
`timescale 1ns / 1ps

module ppd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ppd_pkg::q_status_t status_i,
  output logic               pop_o,
  ppd_event_if.source        event_o
);
  import ppd_pkg::*;

  logic    valid_q;
  result_t out_q;

  // Load a new word whenever the output register is free or being taken.
  assign pop_o = !status_i.empty && (!valid_q || event_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || event_o.ready) begin
      valid_q <= !status_i.empty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= status_i.head;
    end
  end

  // Drive the result channel from the output register.
  assign event_o.valid            = valid_q;
  assign event_o.event_valid      = out_q.event_valid;
  assign event_o.row_index        = out_q.row_index;
  assign event_o.channel_index    = out_q.channel_index;
  assign event_o.present_mask     = out_q.present_mask;
  assign event_o.note_value       = out_q.fields[0*ByteW +: ByteW];
  assign event_o.instrument_value = out_q.fields[1*ByteW +: ByteW];
  assign event_o.first_command    = out_q.fields[2*ByteW +: ByteW];
  assign event_o.first_param      = out_q.fields[3*ByteW +: ByteW];
  assign event_o.second_command   = out_q.fields[4*ByteW +: ByteW];
  assign event_o.second_param     = out_q.fields[5*ByteW +: ByteW];
  assign event_o.pattern_end      = out_q.pattern_end;

endmodule

[src/packed_pattern_event_decoder.sv]
// Packed pattern event decoder.
// Bytes arrive on byte_i (data_byte, last_byte) with a valid/ready handshake;
// each accepted word yields zero or one result word on event_o. A result
// carries a decoded event (event_valid set) and/or the end-of-pattern mark.
// Configuration (channel count at index 0, row count at index 1) is written
// through cfg_we_i/cfg_idx_i/cfg_data_i; the user must write it only while
// the block is idle, as the block itself does not enforce this.
// Throughput: one byte per cycle, sustained; byte_i.ready drops only while
// the two-entry result queue is full.
// A byte's result word is written into the queue at the edge that accepts
// the byte, then moves into the output register, from which the receiver
// takes it.
// Reset clears the parse state, empties the queue and sets the channel count
// to 32 and the row count to 64.
// When the receiver stalls, the output register holds its word, the queue
// fills, and once it is full the block stops taking bytes; nothing is lost.
`timescale 1ns / 1ps

module packed_pattern_event_decoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ppd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ppd_pkg::CfgDataW-1:0] cfg_data_i,
  ppd_byte_if.sink                     byte_i,
  ppd_event_if.source                  event_o
);
  import ppd_pkg::*;

  logic      accept;
  logic      push;
  logic      pop;
  logic      full;
  result_t   result;
  q_status_t q_status;

  // Bytes are taken whenever the queue has room.
  assign byte_i.ready = !full;
  assign accept       = byte_i.valid && !full;

  ppd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .data_byte_i (byte_i.data_byte),
    .last_byte_i (byte_i.last_byte),
    .push_o      (push),
    .result_o    (result)
  );

  ppd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (result),
    .pop_i    (pop),
    .full_o   (full),
    .status_o (q_status)
  );

  ppd_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (q_status),
    .pop_o    (pop),
    .event_o  (event_o)
  );

endmodule

[tb/tb_packed_pattern_event_decoder.sv]
// Self-checking testbench for the packed pattern event decoder.
// Depends on ppd_pkg, the ppd_byte_if/ppd_event_if interfaces and the decoder RTL.
// It drives byte words, predicts each result word and checks it field by field.
`timescale 1ns / 1ps

module tb_packed_pattern_event_decoder;
  import ppd_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned MaxShown   = 10;

  // Tracks the parse state of the decoder and holds the result words still due.
  class decoded_event_board;
    logic [ChanRegW-1:0] chan_reg;
    logic [RowRegW-1:0]  rows_reg;
    logic [RowW-1:0]     row_cnt;
    logic [ChanCntW-1:0] chan_cnt;
    logic [FlagW-1:0]    flags_left;
    bit                  mid_event;
    logic [FieldsW-1:0]  field_bytes;
    logic [MaskW-1:0]    field_mask;
    result_t             awaited_events[$];
    int                  mismatches;

    function new();
      chan_reg   = ChannelCountReset;
      rows_reg   = RowCountReset;
      mismatches = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      row_cnt     = '0;
      chan_cnt    = '0;
      flags_left  = '0;
      mid_event   = 1'b0;
      field_bytes = '0;
      field_mask  = '0;
    endfunction

    function void set_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
      case (idx)
        RegChannelCount: chan_reg = val[ChanRegW-1:0];
        RegRowCount:     rows_reg = val[RowRegW-1:0];
        default: ;
      endcase
    endfunction

    // Register values above the limits are clamped.
    function logic [ChanCntW-1:0] chan_limit();
      if (ChanCntW'(chan_reg) < MaxChannelCount) return ChanCntW'(chan_reg);
      return MaxChannelCount;
    endfunction

    function logic [RowW-1:0] row_limit();
      if (rows_reg < MaxRowCount) return rows_reg;
      return MaxRowCount;
    endfunction

    function result_t gathered_event();
      result_t r;
      r = '0;
      r.event_valid   = 1'b1;
      r.row_index     = row_cnt;
      r.channel_index = chan_cnt[ChanW-1:0];
      r.present_mask  = field_mask;
      r.fields        = field_bytes;
      return r;
    endfunction

    // Advances the parse state by one accepted byte word and queues the result
    // word it causes. Returns 1 if the byte was not ignored for lack of rows.
    function bit take_byte(input logic [ByteW-1:0] b, input logic lst);
      result_t r;
      bit      have;
      bit      done;
      bit      used;
      int      pos;
      r    = '0;
      have = 1'b0;
      done = 1'b0;
      used = row_cnt < row_limit();
      if (used) begin
        if (!mid_event) begin
          if (b == '0) begin
            // Row end: back to channel 0 on the next row.
            chan_cnt = '0;
            row_cnt  = row_cnt + 1'b1;
          end else begin
            mid_event   = 1'b1;
            flags_left  = b[FlagW-1:0];
            field_bytes = FieldsInit;
            field_mask  = '0;
            done        = (flags_left == '0);
          end
        end else begin
          // The lowest flag still set says what this byte is.
          pos = 0;
          while (pos < FlagW && !flags_left[pos]) pos++;
          if (pos == 0) begin
            chan_cnt = b;
          end else if (pos < FlagW) begin
            field_bytes[ByteW*(pos-1) +: ByteW] = b;
            field_mask[pos-1] = 1'b1;
          end
          if (pos < FlagW) flags_left[pos] = 1'b0;
          done = (flags_left == '0);
        end
        if (done) begin
          if (chan_cnt < chan_limit()) begin
            r    = gathered_event();
            have = 1'b1;
          end
          if (chan_cnt != ChannelSat) chan_cnt = chan_cnt + 1'b1;
          mid_event = 1'b0;
        end
      end
      // The final byte flushes a partial event and always yields a word.
      if (lst) begin
        if (mid_event && chan_cnt < chan_limit()) r = gathered_event();
        r.pattern_end = 1'b1;
        have = 1'b1;
        clear_parse();
      end
      if (have) awaited_events.push_back(r);
      return used;
    endfunction

    function void match_event(input result_t got);
      result_t want;
      bit      bad;
      if (awaited_events.size() == 0) begin
        if (mismatches < MaxShown)
          $display("%0t: unexpected result word: ev=%0b row=%0d ch=%0d mask=%b",
                   $time, got.event_valid, got.row_index, got.channel_index,
                   got.present_mask, " fields=%h end=%0b", got.fields, got.pattern_end);
        mismatches++;
        return;
      end
      want = awaited_events.pop_front();
      bad = (got.event_valid !== want.event_valid) || (got.row_index !== want.row_index) ||
            (got.channel_index !== want.channel_index) ||
            (got.present_mask !== want.present_mask) ||
            (got.pattern_end !== want.pattern_end);
      for (int k = 0; k < MaskW; k++)
        if (got.fields[ByteW*k +: ByteW] !== want.fields[ByteW*k +: ByteW]) bad = 1'b1;
      if (bad) begin
        if (mismatches < MaxShown)
          $display("%0t: result mismatch: expected ev=%0b row=%0d ch=%0d mask=%b",
                   $time, want.event_valid, want.row_index, want.channel_index,
                   want.present_mask, " fields=%h end=%0b,", want.fields, want.pattern_end,
                   " got ev=%0b row=%0d ch=%0d mask=%b",
                   got.event_valid, got.row_index, got.channel_index,
                   got.present_mask, " fields=%h end=%0b", got.fields, got.pattern_end);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  ppd_byte_if  byte_if ();
  ppd_event_if event_if ();

  decoded_event_board board = new();

  int src_gap_pct;
  int sink_gap_pct;
  int hold_req;
  int used_items;
  int cycle_cnt;

  packed_pattern_event_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .byte_i     (byte_if),
    .event_o    (event_if)
  );

  always #5 clk_i = ~clk_i;

  // Run limit.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Both handshakes are observed at the rising edge: the byte word first, then the result.
  always @(posedge clk_i) begin : watch
    result_t seen;
    if (rst_ni) begin
      if (byte_if.valid && byte_if.ready) begin
        if (board.take_byte(byte_if.data_byte, byte_if.last_byte)) used_items++;
      end
      if (event_if.valid && event_if.ready) begin
        seen               = '0;
        seen.event_valid   = event_if.event_valid;
        seen.row_index     = event_if.row_index;
        seen.channel_index = event_if.channel_index;
        seen.present_mask  = event_if.present_mask;
        seen.fields        = {event_if.second_param, event_if.second_command,
                              event_if.first_param, event_if.first_command,
                              event_if.instrument_value, event_if.note_value};
        seen.pattern_end   = event_if.pattern_end;
        board.match_event(seen);
      end
    end
  end

  // Result receiver: random stall bursts, plus one long hold when requested.
  initial begin : receiver
    int stall_left;
    stall_left     = 0;
    event_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req   = 0;
      end
      if (stall_left > 0) begin
        event_if.ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < sink_gap_pct) begin
        stall_left = $urandom_range(0, 15);
        event_if.ready <= 1'b0;
      end else begin
        event_if.ready <= 1'b1;
      end
    end
  end

  // Offers one byte word and returns at the edge where it is taken.
  task automatic send_byte(input logic [ByteW-1:0] b, input logic lst);
    @(negedge clk_i);
    if ($urandom_range(0, 99) < src_gap_pct) begin
      byte_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= b;
    byte_if.last_byte <= lst;
    do @(posedge clk_i); while (!byte_if.ready);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    board.set_reg(idx, val);
  endtask

  // Stops offering words and waits until every due result word has arrived.
  task automatic settle();
    @(negedge clk_i);
    byte_if.valid <= 1'b0;
    while (board.awaited_events.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // One well-formed pattern with random content, sometimes cut short and
  // sometimes with a stray byte mixed in.
  task automatic send_pattern(input int row_span, input int chan_span);
    logic [ByteW-1:0] seq[$];
    logic [ByteW-1:0] flags;
    int               rows;
    int               evs;
    int               cut;
    rows = $urandom_range(1, row_span);
    for (int r = 0; r < rows; r++) begin
      evs = $urandom_range(0, 4);
      for (int e = 0; e < evs; e++) begin
        flags = ByteW'($urandom_range(1, 255));
        seq.push_back(flags);
        if (flags[0])
          seq.push_back(ByteW'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                            : $urandom_range(0, chan_span)));
        for (int k = 1; k < FlagW; k++)
          if (flags[k]) seq.push_back(ByteW'($urandom_range(0, 255)));
      end
      seq.push_back('0);
    end
    cut = seq.size();
    if ($urandom_range(0, 3) == 0) cut = $urandom_range(1, seq.size());
    for (int i = 0; i < cut; i++) begin
      if ($urandom_range(0, 29) == 0) send_byte(ByteW'($urandom_range(0, 255)), i == cut - 1);
      else send_byte(seq[i], i == cut - 1);
    end
  endtask

  // Mostly well-formed patterns, now and then a pattern of pure noise.
  task automatic run_random(input int budget, input int max_pats, input int row_span,
                            input int chan_span);
    int start;
    int pats;
    int len;
    start = used_items;
    pats  = 0;
    while (used_items - start < budget && pats < max_pats) begin
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(1, 30);
        for (int i = 0; i < len; i++)
          send_byte(ByteW'($urandom_range(0, 255)), i == len - 1);
      end else begin
        send_pattern(row_span, chan_span);
      end
      pats++;
    end
  endtask

  initial begin : stimulus
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = '0;
    cfg_data          = '0;
    byte_if.valid     = 1'b0;
    byte_if.data_byte = '0;
    byte_if.last_byte = 1'b0;
    src_gap_pct       = 10;
    sink_gap_pct      = 10;
    hold_req          = 0;
    used_items        = 0;
    cycle_cnt         = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed words at the reset configuration of 32 channels and 64 rows.
    // A flag byte with no field bits completes at once with an empty mask.
    send_byte(8'h80, 1'b0);
    // Every flag bit, explicit channel 31, field bytes at their extremes.
    send_byte(8'hff, 1'b0);
    send_byte(8'd31, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hfe, 1'b0);
    send_byte(8'haa, 1'b0);
    send_byte(8'h55, 1'b0);
    // Channel 32 is out of range: the event is dropped.
    send_byte(8'h02, 1'b0);
    send_byte(8'h3c, 1'b0);
    send_byte(8'h00, 1'b0);
    // Channel 254 is dropped, then the counter saturates at 255.
    send_byte(8'h01, 1'b0);
    send_byte(8'hfe, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h03, 1'b0);
    // Partial event flushed by the final byte.
    send_byte(8'h7e, 1'b0);
    send_byte(8'h40, 1'b0);
    send_byte(8'h09, 1'b1);
    // A bare flag byte as the final byte, then an end mark with no event.
    send_byte(8'h81, 1'b1);
    send_byte(8'h00, 1'b1);
    settle();

    // Both registers above their limits: 32 channels and 999 rows take effect.
    write_reg(RegChannelCount, CfgDataW'(63));
    write_reg(RegRowCount, CfgDataW'(1023));
    src_gap_pct = 5;
    repeat (998) send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'd31, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'd32, 1'b0);
    send_byte(8'h00, 1'b0);
    // The last row is reached: these words are ignored but the end still counts.
    send_byte(8'h82, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h80, 1'b1);
    settle();
    run_random(20, 1000, 4, 63);
    settle();

    // No rows and no channels: only end marks come out.
    write_reg(RegChannelCount, CfgDataW'(0));
    write_reg(RegRowCount, CfgDataW'(0));
    src_gap_pct  = 20;
    sink_gap_pct = 20;
    run_random(1000, 2, 3, 31);
    settle();

    // One row of one channel.
    write_reg(RegChannelCount, CfgDataW'(1));
    write_reg(RegRowCount, CfgDataW'(1));
    src_gap_pct  = 30;
    sink_gap_pct = 0;
    run_random(15, 1000, 3, 3);
    settle();

    // No channels but some rows: every event is dropped.
    write_reg(RegChannelCount, CfgDataW'(0));
    write_reg(RegRowCount, CfgDataW'(5));
    src_gap_pct  = 0;
    sink_gap_pct = 30;
    run_random(15, 1000, 6, 7);
    settle();

    // Random sizes; the receiver holds off long enough for the block to stall.
    write_reg(RegChannelCount, CfgDataW'($urandom_range(1, 40)));
    write_reg(RegRowCount, CfgDataW'($urandom_range(1, 12)));
    src_gap_pct  = 15;
    sink_gap_pct = 15;
    hold_req     = 300;
    run_random(60, 1000, 8, 40);
    settle();

    // Back to the reset values, with both sides running flat out.
    write_reg(RegChannelCount, CfgDataW'(ChannelCountReset));
    write_reg(RegRowCount, CfgDataW'(RowCountReset));
    src_gap_pct  = 0;
    sink_gap_pct = 0;
    run_random(20, 1000, 6, 35);
    settle();

    if (board.mismatches == 0 && board.awaited_events.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
src/ppd_pkg.sv
src/ppd_if.sv
src/ppd_front.sv
src/ppd_queue.sv
src/ppd_back.sv
src/packed_pattern_event_decoder.sv
tb/tb_packed_pattern_event_decoder.sv
